[design/ams_pkg.sv]
// Shared constants, payload types and widths for the sample magnitude block.
package ams_pkg;

   localparam int RAW_W       = 16;
   localparam int AXIS_W      = 12;
   localparam int KIND_W      = 2;
   localparam int PROD_W      = 23;
   localparam int PMAG_W      = 21;
   localparam int RECIP_W     = 22;
   localparam int QM_W        = PMAG_W + RECIP_W;
   localparam int QUO_W       = 11;
   localparam int SQ_W        = 23;
   localparam int SUM_W       = 24;
   localparam int ROOT_W      = 12;
   localparam int ROOT_STAGES = ROOT_W;
   localparam int LANE_STAGES = 5;
   localparam int SHR_AMOUNT  = 4;

   localparam int SCALE_MUL   = 61;
   localparam int SCALE_DIV   = 1000;
   localparam int DIV_SHIFT   = 31;
   // Rounded-up reciprocal of the divisor; exact for products below 2**21.
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV));

   localparam logic [ROOT_W-1:0] MAG_MAX = ROOT_W'(3547);

   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MILLI = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SHIFT = 2'd2;

   typedef struct packed {
      logic signed [RAW_W-1:0] raw_x;
      logic signed [RAW_W-1:0] raw_y;
      logic signed [RAW_W-1:0] raw_z;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [AXIS_W-1:0] x_mg;
      logic signed [AXIS_W-1:0] y_mg;
      logic signed [AXIS_W-1:0] z_mg;
      logic        [ROOT_W-1:0] magnitude;
   } rsp_type;

   // Fields that ride along with the root computation.
   typedef struct packed {
      logic                     ok;
      logic signed [AXIS_W-1:0] x_mg;
      logic signed [AXIS_W-1:0] y_mg;
      logic signed [AXIS_W-1:0] z_mg;
   } side_type;

endpackage

[design/ams_stream_if.sv]
// Valid/ready stream channel carrying one payload beat per handshake.
interface ams_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[design/ams_lane.sv]
// One axis lane: scales a raw word to milli-g and squares its magnitude.
module ams_lane (
   input  logic                              clock,
   input  logic [ams_pkg::LANE_STAGES-1:0]   adv,
   input  logic [ams_pkg::KIND_W-1:0]        kind,
   input  logic signed [ams_pkg::RAW_W-1:0]  raw,
   output logic                              ok,
   output logic signed [ams_pkg::AXIS_W-1:0] axis,
   output logic [ams_pkg::SQ_W-1:0]          square
);
   import ams_pkg::*;

   logic signed [RAW_W-1:0]  raw_ff;
   logic [KIND_W-1:0]        kind0_ff, kind1_ff, kind2_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic signed [AXIS_W-1:0] shr1_ff, shr2_ff;
   logic                     neg_ff;
   logic [QM_W-1:0]          qm_ff;
   logic signed [AXIS_W-1:0] axis3_ff, axis4_ff;
   logic [AXIS_W-1:0]        mag3_ff;
   logic                     ok3_ff, ok4_ff;
   logic [SQ_W-1:0]          sq_ff;

   logic signed [RAW_W-1:0]  shr_full;
   logic [PMAG_W-1:0]        pmag;
   logic [QUO_W-1:0]         quo;
   logic signed [AXIS_W-1:0] axis_in;
   logic [AXIS_W-1:0]        mag_in;

   always_comb begin
      shr_full = raw_ff >>> SHR_AMOUNT;
      pmag     = prod_ff[PROD_W-1] ? PMAG_W'(-prod_ff) : PMAG_W'(prod_ff);
      quo      = qm_ff[DIV_SHIFT +: QUO_W];
      case (kind2_ff)
         KIND_MILLI: axis_in = neg_ff ? -AXIS_W'(quo) : AXIS_W'(quo);
         KIND_SHIFT: axis_in = shr2_ff;
         default:    axis_in = '0;
      endcase
      mag_in = axis_in[AXIS_W-1] ? AXIS_W'(-axis_in) : AXIS_W'(axis_in);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         raw_ff   <= raw;
         kind0_ff <= kind;
      end
      if (adv[1]) begin
         prod_ff  <= PROD_W'(raw_ff) * PROD_W'(SCALE_MUL);
         shr1_ff  <= AXIS_W'(shr_full);
         kind1_ff <= kind0_ff;
      end
      if (adv[2]) begin
         neg_ff   <= prod_ff[PROD_W-1];
         qm_ff    <= QM_W'(pmag) * QM_W'(DIV_RECIP);
         shr2_ff  <= shr1_ff;
         kind2_ff <= kind1_ff;
      end
      if (adv[3]) begin
         axis3_ff <= axis_in;
         mag3_ff  <= mag_in;
         ok3_ff   <= (kind2_ff == KIND_MILLI) || (kind2_ff == KIND_SHIFT);
      end
      if (adv[4]) begin
         sq_ff    <= SQ_W'(mag3_ff) * SQ_W'(mag3_ff);
         axis4_ff <= axis3_ff;
         ok4_ff   <= ok3_ff;
      end
   end

   assign ok     = ok4_ff;
   assign axis   = axis4_ff;
   assign square = sq_ff;

endmodule

[design/ams_root.sv]
// Pipelined floor square root, one result bit resolved per stage.
module ams_root (
   input  logic                              clock,
   input  logic [ams_pkg::ROOT_STAGES-1:0]   adv,
   input  logic [ams_pkg::SUM_W-1:0]         sum_in,
   input  ams_pkg::side_type                 side_in,
   output logic [ams_pkg::ROOT_W-1:0]        root,
   output ams_pkg::side_type                 side_out
);
   import ams_pkg::*;

   logic [SUM_W-1:0]  rem_ff  [ROOT_STAGES];
   logic [ROOT_W-1:0] root_ff [ROOT_STAGES];
   side_type          side_ff [ROOT_STAGES];

   for (genvar j = 0; j < ROOT_STAGES; j++) begin : g_step
      localparam int K = ROOT_STAGES - 1 - j;

      logic [SUM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      side_type          side_prev;
      logic [SUM_W:0]    trial;
      logic              take;

      if (j == 0) begin : g_first
         assign rem_prev  = sum_in;
         assign root_prev = '0;
         assign side_prev = side_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      // (r + 2^K)^2 - r^2, compared against what is left of the radicand.
      always_comb begin
         trial = ((SUM_W+1)'(root_prev) << (K + 1)) + ((SUM_W+1)'(1) << (2 * K));
         take  = {1'b0, rem_prev} >= trial;
      end

      always_ff @(posedge clock) begin
         if (adv[j]) begin
            rem_ff[j]  <= take ? SUM_W'({1'b0, rem_prev} - trial) : rem_prev;
            root_ff[j] <= take ? (root_prev | (ROOT_W'(1) << K)) : root_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign root     = root_ff[ROOT_STAGES-1];
   assign side_out = side_ff[ROOT_STAGES-1];

endmodule

[design/accel_sample_magnitude.sv]
// Top level: accelerometer sample scaling and vector magnitude pipeline.
//
//   channel    | direction | beat contents
//   -----------+-----------+------------------------------------------
//   req_chan   | in        | raw_x, raw_y, raw_z (signed 16-bit words)
//   rsp_chan   | out       | ok, x_mg, y_mg, z_mg, magnitude
//   csr_we/... | in        | sensor_kind write, no read-back
//
// One beat is accepted per cycle unless an output stall fills every stage;
// each passes 18 register stages: five in the three axis lanes, one for
// the sum of squares and twelve for the root, one bit per stage. The
// accepting edge loads the first stage; the last holds the beat until taken.
// Reset clears the sensor kind and all stage valid bits.
// Each stage holds while the stage after it is full and stalled, so bubbles
// close up and new beats enter while a finished result waits at the output.
module accel_sample_magnitude (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [ams_pkg::KIND_W-1:0]   csr_wdata,
   ams_stream_if.sink                   req_chan,
   ams_stream_if.source                 rsp_chan
);
   import ams_pkg::*;

   localparam int MERGE_STAGE = LANE_STAGES;
   localparam int ROOT_FIRST  = LANE_STAGES + 1;
   localparam int NS          = ROOT_FIRST + ROOT_STAGES;

   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [NS-1:0]     valid_ff, valid_in;
   logic [NS-1:0]     move;

   logic                     ok_x, ok_y, ok_z;
   logic signed [AXIS_W-1:0] axis_x, axis_y, axis_z;
   logic [SQ_W-1:0]          sq_x, sq_y, sq_z;

   logic [SUM_W-1:0]  sum_ff;
   side_type          side_ff;
   side_type          side_out;
   logic [ROOT_W-1:0] root;

   // A stage may load when it is empty or its contents move on this cycle.
   always_comb begin
      move[NS-1] = !valid_ff[NS-1] || rsp_chan.ready;
      for (int i = NS - 2; i >= 0; i--) begin
         move[i] = !valid_ff[i] || move[i+1];
      end
      valid_in[0] = move[0] ? req_chan.valid : valid_ff[0];
      for (int i = 1; i < NS; i++) begin
         valid_in[i] = move[i] ? valid_ff[i-1] : valid_ff[i];
      end
      kind_in = csr_we ? csr_wdata : kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_NONE;
         valid_ff <= '0;
      end else begin
         kind_ff  <= kind_in;
         valid_ff <= valid_in;
      end
   end

   ams_lane u_lane_x (
      .clock  (clock),
      .adv    (move[LANE_STAGES-1:0]),
      .kind   (kind_ff),
      .raw    (req_chan.payload.raw_x),
      .ok     (ok_x),
      .axis   (axis_x),
      .square (sq_x)
   );

   ams_lane u_lane_y (
      .clock  (clock),
      .adv    (move[LANE_STAGES-1:0]),
      .kind   (kind_ff),
      .raw    (req_chan.payload.raw_y),
      .ok     (ok_y),
      .axis   (axis_y),
      .square (sq_y)
   );

   ams_lane u_lane_z (
      .clock  (clock),
      .adv    (move[LANE_STAGES-1:0]),
      .kind   (kind_ff),
      .raw    (req_chan.payload.raw_z),
      .ok     (ok_z),
      .axis   (axis_z),
      .square (sq_z)
   );

   // Merge stage: the lanes see the same kind, so their flags agree.
   always_ff @(posedge clock) begin
      if (move[MERGE_STAGE]) begin
         sum_ff       <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
         side_ff.ok   <= ok_x && ok_y && ok_z;
         side_ff.x_mg <= axis_x;
         side_ff.y_mg <= axis_y;
         side_ff.z_mg <= axis_z;
      end
   end

   ams_root u_root (
      .clock    (clock),
      .adv      (move[NS-1:ROOT_FIRST]),
      .sum_in   (sum_ff),
      .side_in  (side_ff),
      .root     (root),
      .side_out (side_out)
   );

   assign req_chan.ready              = move[0];
   assign rsp_chan.valid              = valid_ff[NS-1];
   assign rsp_chan.payload.ok         = side_out.ok;
   assign rsp_chan.payload.x_mg       = side_out.x_mg;
   assign rsp_chan.payload.y_mg       = side_out.y_mg;
   assign rsp_chan.payload.z_mg       = side_out.z_mg;
   assign rsp_chan.payload.magnitude  = root;

`ifndef SYNTH
   a_zero_when_unconfigured: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.payload.ok |->
         rsp_chan.payload.x_mg == '0 && rsp_chan.payload.y_mg == '0 &&
         rsp_chan.payload.z_mg == '0 && rsp_chan.payload.magnitude == '0)
      else $error("unconfigured result carries nonzero fields");

   a_magnitude_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.payload.magnitude <= MAG_MAX)
      else $error("magnitude above the largest reachable root");

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.ready |-> req_chan.ready)
      else $error("input stalled while the output drains");

   a_first_stage_loads: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> valid_ff[0])
      else $error("accepted beat did not reach the first stage");
`endif

endmodule
